// ===== sv/fcsem_pkg.sv =====
// Shared types, codes and microprogram addresses of the counting semaphore.
package fcsem_pkg;

  localparam int unsigned ID_FIELD_W    = 16;
  localparam int unsigned COUNT_FIELD_W = 7;
  localparam int unsigned LIMIT_REG_W   = 7;
  localparam int unsigned PC_W          = 5;

  typedef enum logic [2:0] {
    ST_GRANTED    = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_RELEASED   = 3'd2,
    ST_NOT_HOLDER = 3'd3,
    ST_QUEUE_FULL = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ENQ,
    ACT_TAKE_ID,
    ACT_TAKE_W,
    ACT_CLR_IDX,
    ACT_RD_SCAN,
    ACT_RD_LAST,
    ACT_FILL_HOLE,
    ACT_DEQ
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_IS_UP,
    C_ID_ZERO,
    C_CAN_GRANT,
    C_Q_FULL,
    C_IDX_END,
    C_MISS_MORE,
    C_MISS,
    C_CAN_WAKE
  } cond_e;

  typedef logic [PC_W-1:0] pc_t;

  // Microprogram entry points.
  localparam pc_t S_IDLE    = 5'd0;
  localparam pc_t S_DISP    = 5'd1;
  localparam pc_t S_DN_ZERO = 5'd2;
  localparam pc_t S_DN_CAN  = 5'd3;
  localparam pc_t S_DN_FULL = 5'd4;
  localparam pc_t S_DN_ENQ  = 5'd5;
  localparam pc_t S_DN_TAKE = 5'd6;
  localparam pc_t S_UP      = 5'd7;
  localparam pc_t S_UP_EMPT = 5'd8;
  localparam pc_t S_SCAN    = 5'd9;
  localparam pc_t S_SCAN_CK = 5'd10;
  localparam pc_t S_SCAN_NH = 5'd11;
  localparam pc_t S_RD_LAST = 5'd12;
  localparam pc_t S_FILL    = 5'd13;
  localparam pc_t S_UP_WAKE = 5'd14;
  localparam pc_t S_E_REL   = 5'd15;
  localparam pc_t S_WAKE    = 5'd16;
  localparam pc_t S_WAKE_TK = 5'd17;
  localparam pc_t S_E_WGR   = 5'd18;
  localparam pc_t S_E_NH    = 5'd19;
  localparam pc_t S_E_QF    = 5'd20;
  localparam pc_t S_E_QD    = 5'd21;
  localparam pc_t S_E_GR    = 5'd22;

  typedef struct packed {
    act_e    act;
    cond_e   cond;
    pc_t     target;
    logic    emit;
    status_e status;
    logic    subj_waiter;
    logic    last;
  } uword_t;

  typedef struct packed {
    logic no_input;
    logic is_up;
    logic id_zero;
    logic can_grant;
    logic q_full;
    logic idx_end;
    logic miss_more;
    logic miss;
    logic can_wake;
  } flags_t;

endpackage

// ===== sv/fcsem_seq.sv =====
// Microcode sequencer: program ROM, step counter and conditional jumps.
module fcsem_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fcsem_pkg::flags_t flags_i,
  input  logic            out_free_i,
  output fcsem_pkg::uword_t ctrl_o,
  output logic            fire_o,
  output logic            idle_o
);
  import fcsem_pkg::*;

  pc_t    pc_q, pc_d;
  uword_t word;
  logic   hold;
  logic   cond_true;

  function automatic uword_t mk(input act_e a, input cond_e c, input pc_t t, input logic e,
                                input status_e s, input logic w, input logic l);
    uword_t u;
    u.act         = a;
    u.cond        = c;
    u.target      = t;
    u.emit        = e;
    u.status      = s;
    u.subj_waiter = w;
    u.last        = l;
    return u;
  endfunction

  function automatic uword_t rom(input pc_t a);
    uword_t u;
    case (a)
      S_IDLE:    u = mk(ACT_NONE, C_NO_INPUT, S_IDLE, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_DISP:    u = mk(ACT_NONE, C_IS_UP, S_UP, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_DN_ZERO: u = mk(ACT_NONE, C_ID_ZERO, S_E_NH, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_DN_CAN:  u = mk(ACT_NONE, C_CAN_GRANT, S_DN_TAKE, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_DN_FULL: u = mk(ACT_NONE, C_Q_FULL, S_E_QF, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_DN_ENQ:  u = mk(ACT_ENQ, C_ALWAYS, S_E_QD, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_DN_TAKE: u = mk(ACT_TAKE_ID, C_ALWAYS, S_E_GR, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_UP:      u = mk(ACT_CLR_IDX, C_ID_ZERO, S_E_NH, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_UP_EMPT: u = mk(ACT_NONE, C_IDX_END, S_E_NH, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_SCAN:    u = mk(ACT_RD_SCAN, C_NEVER, S_IDLE, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_SCAN_CK: u = mk(ACT_NONE, C_MISS_MORE, S_SCAN, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_SCAN_NH: u = mk(ACT_NONE, C_MISS, S_E_NH, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_RD_LAST: u = mk(ACT_RD_LAST, C_NEVER, S_IDLE, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_FILL:    u = mk(ACT_FILL_HOLE, C_NEVER, S_IDLE, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_UP_WAKE: u = mk(ACT_NONE, C_CAN_WAKE, S_WAKE, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_E_REL:   u = mk(ACT_NONE, C_ALWAYS, S_IDLE, 1'b1, ST_RELEASED, 1'b0, 1'b1);
      S_WAKE:    u = mk(ACT_DEQ, C_NEVER, S_IDLE, 1'b1, ST_RELEASED, 1'b0, 1'b0);
      S_WAKE_TK: u = mk(ACT_TAKE_W, C_NEVER, S_IDLE, 1'b0, ST_GRANTED, 1'b0, 1'b0);
      S_E_WGR:   u = mk(ACT_NONE, C_ALWAYS, S_IDLE, 1'b1, ST_GRANTED, 1'b1, 1'b1);
      S_E_NH:    u = mk(ACT_NONE, C_ALWAYS, S_IDLE, 1'b1, ST_NOT_HOLDER, 1'b0, 1'b1);
      S_E_QF:    u = mk(ACT_NONE, C_ALWAYS, S_IDLE, 1'b1, ST_QUEUE_FULL, 1'b0, 1'b1);
      S_E_QD:    u = mk(ACT_NONE, C_ALWAYS, S_IDLE, 1'b1, ST_QUEUED, 1'b0, 1'b1);
      S_E_GR:    u = mk(ACT_NONE, C_ALWAYS, S_IDLE, 1'b1, ST_GRANTED, 1'b0, 1'b1);
      default:   u = mk(ACT_NONE, C_ALWAYS, S_IDLE, 1'b0, ST_GRANTED, 1'b0, 1'b0);
    endcase
    return u;
  endfunction

  always_comb begin
    word = rom(pc_q);
    case (word.cond)
      C_NEVER:     cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_NO_INPUT:  cond_true = flags_i.no_input;
      C_IS_UP:     cond_true = flags_i.is_up;
      C_ID_ZERO:   cond_true = flags_i.id_zero;
      C_CAN_GRANT: cond_true = flags_i.can_grant;
      C_Q_FULL:    cond_true = flags_i.q_full;
      C_IDX_END:   cond_true = flags_i.idx_end;
      C_MISS_MORE: cond_true = flags_i.miss_more;
      C_MISS:      cond_true = flags_i.miss;
      C_CAN_WAKE:  cond_true = flags_i.can_wake;
      default:     cond_true = 1'b0;
    endcase
    // A step that emits a result waits here until the output register is free.
    hold = word.emit && !out_free_i;
    if (hold) begin
      pc_d = pc_q;
    end else if (cond_true) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = word;
  assign fire_o = !hold;
  assign idle_o = (pc_q == S_IDLE);

endmodule

// ===== sv/fifo_counting_semaphore.sv =====
// Counting semaphore with a FIFO wait queue, run by a microcoded sequencer.
// A down needs no table scan; an up scans the holder entries one at a time.
// One item at a time; the holder table scan through its single port sets the rate.
// Reset empties the table and the queue and sets max_holders to 1; no clearing pass.
module fifo_counting_semaphore #(
  parameter int unsigned SLOTS   = 64,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [fcsem_pkg::LIMIT_REG_W-1:0]      cfg_max_holders_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   operation_i,
  input  logic [fcsem_pkg::ID_FIELD_W-1:0]       requester_id_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [fcsem_pkg::ID_FIELD_W-1:0]       subject_id_o,
  output logic [2:0]                             status_o,
  output logic [fcsem_pkg::COUNT_FIELD_W-1:0]    holder_count_o,
  output logic                                   last_o
);
  import fcsem_pkg::*;

  localparam int unsigned IdW   = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned CntW  = $clog2(SLOTS + 1);
  localparam int unsigned LimW  = (CntW > LIMIT_REG_W) ? CntW : LIMIT_REG_W;

  // Holders are kept packed in entries 0 .. count-1; a release moves the last
  // holder into the freed entry.
  logic [IdW-1:0] hold_mem [SLOTS];
  logic [IdW-1:0] wait_mem [SLOTS];

  logic [LIMIT_REG_W-1:0] max_holders_q;
  logic [CntW-1:0]        cnt_q, qcount_q, idx_q;
  logic [SlotW-1:0]       head_q, tail_q;
  logic                   op_q;
  logic [IdW-1:0]         id_q, h_rd_q, q_rd_q;
  logic                   out_valid_q;
  logic [IdW-1:0]         out_id_q;
  status_e                out_status_q;
  logic [CntW-1:0]        out_cnt_q;
  logic                   out_last_q;

  logic [LimW-1:0] mh_ext, limit, cnt_ext;
  logic [CntW-1:0] cnt_m1, idx_m1;
  logic            in_accept, out_free, below_limit;
  logic            fire, idle;
  uword_t          ctrl;
  flags_t          flags;

  function automatic logic [SlotW-1:0] q_next(input logic [SlotW-1:0] p);
    return (p == SlotW'(SLOTS - 1)) ? '0 : p + SlotW'(1);
  endfunction

  fcsem_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flags_i    (flags),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .fire_o     (fire),
    .idle_o     (idle)
  );

  always_comb begin
    mh_ext  = LimW'(max_holders_q);
    cnt_ext = LimW'(cnt_q);
    if (mh_ext == '0) begin
      limit = LimW'(1);
    end else if (mh_ext > LimW'(SLOTS)) begin
      limit = LimW'(SLOTS);
    end else begin
      limit = mh_ext;
    end
    below_limit = cnt_ext < limit;
    cnt_m1      = cnt_q - CntW'(1);
    idx_m1      = idx_q - CntW'(1);

    flags.no_input  = !in_valid_i;
    flags.is_up     = op_q;
    flags.id_zero   = (id_q == '0);
    flags.can_grant = (qcount_q == '0) && below_limit;
    flags.q_full    = (qcount_q == CntW'(SLOTS));
    flags.idx_end   = (idx_q == cnt_q);
    flags.miss      = (h_rd_q != id_q);
    flags.miss_more = (h_rd_q != id_q) && (idx_q != cnt_q);
    flags.can_wake  = (qcount_q != '0) && below_limit;
  end

  assign in_stall_o = !idle;
  assign in_accept  = in_valid_i && idle;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_holders_q <= LIMIT_REG_W'(1);
      cnt_q         <= '0;
      qcount_q      <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_holders_q <= cfg_max_holders_i;
      end
      if (fire) begin
        case (ctrl.act)
          ACT_ENQ: begin
            tail_q   <= q_next(tail_q);
            qcount_q <= qcount_q + CntW'(1);
          end
          ACT_DEQ: begin
            head_q   <= q_next(head_q);
            qcount_q <= qcount_q - CntW'(1);
          end
          ACT_TAKE_ID, ACT_TAKE_W: cnt_q <= cnt_q + CntW'(1);
          ACT_FILL_HOLE:           cnt_q <= cnt_m1;
          default: ;
        endcase
      end
      if (fire && ctrl.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q <= operation_i;
      id_q <= requester_id_i[IdW-1:0];
    end
    if (fire) begin
      case (ctrl.act)
        ACT_CLR_IDX: idx_q <= '0;
        ACT_RD_SCAN: begin
          h_rd_q <= hold_mem[idx_q[SlotW-1:0]];
          idx_q  <= idx_q + CntW'(1);
        end
        ACT_RD_LAST:   h_rd_q <= hold_mem[cnt_m1[SlotW-1:0]];
        ACT_FILL_HOLE: hold_mem[idx_m1[SlotW-1:0]] <= h_rd_q;
        ACT_TAKE_ID:   hold_mem[cnt_q[SlotW-1:0]] <= id_q;
        ACT_TAKE_W:    hold_mem[cnt_q[SlotW-1:0]] <= q_rd_q;
        ACT_DEQ:       q_rd_q <= wait_mem[head_q];
        ACT_ENQ:       wait_mem[tail_q] <= id_q;
        default: ;
      endcase
      if (ctrl.emit) begin
        out_id_q     <= ctrl.subj_waiter ? q_rd_q : id_q;
        out_status_q <= ctrl.status;
        out_cnt_q    <= cnt_q;
        out_last_q   <= ctrl.last;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign subject_id_o   = ID_FIELD_W'(out_id_q);
  assign status_o       = out_status_q;
  assign holder_count_o = COUNT_FIELD_W'(out_cnt_q);
  assign last_o         = out_last_q;

endmodule
